// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the steering block.
// Bodies expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LFS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LFS_NEVER(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define LFS_ASSERT(label, prop, msg)
`define LFS_NEVER(label, prop, msg)
`endif
`endif

// ===== rtl/lfs_pkg.sv =====
// Types and constants for the line-follow steering block.
// No dependencies; used by all lfs modules.
package lfs_pkg;

    localparam int MUL_W  = 21;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [2:0] MODE_BULLSEYE  = 3'd0;
    localparam logic [2:0] MODE_SAFEZONE  = 3'd1;
    localparam logic [2:0] MODE_START     = 3'd2;
    localparam logic [2:0] MODE_LEFT_RED  = 3'd3;
    localparam logic [2:0] MODE_RIGHT_RED = 3'd4;
    localparam logic [2:0] MODE_THIRD_RED = 3'd5;
    localparam logic [2:0] MODE_TIMED     = 3'd6;

    localparam logic [1:0] CFG_EXIT_MODE  = 2'd0;
    localparam logic [1:0] CFG_STEER_GAIN = 2'd1;
    localparam logic [1:0] CFG_EXIT_COUNT = 2'd2;

    localparam logic [15:0] TAPE_L = 16'd100;
    localparam logic [15:0] SPAN_L = 16'd200;
    localparam logic [15:0] TAPE_R = 16'd120;
    localparam logic [15:0] SPAN_R = 16'd280;

    // floor(x/200) = floor((x>>3) * RECIP_L >> 24); floor(x/280) = (x>>3) * RECIP_R >> 26
    localparam logic [19:0] RECIP_L = 20'd671089;
    localparam logic [20:0] RECIP_R = 21'd1917397;
    localparam logic [18:0] HALF_L3 = 19'd12;
    localparam logic [19:0] HALF_R3 = 20'd17;

    localparam logic [15:0] ONE_Q14 = 16'd16384;

    typedef struct packed {
        logic [15:0] red_third;
        logic [15:0] green_third;
        logic [15:0] blue_third;
        logic [15:0] green_left;
        logic [15:0] green_right;
        logic [15:0] blue_left;
        logic [15:0] blue_right;
    } sample_t;

    typedef struct packed {
        logic [MUL_W-1:0] opa;
        logic [MUL_W-1:0] opb;
    } mul_req_t;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_NL   = 7'b0000010,
        ST_NR   = 7'b0000100,
        ST_SQ1  = 7'b0001000,
        ST_SQ2  = 7'b0010000,
        ST_GAIN = 7'b0100000,
        ST_FIN  = 7'b1000000
    } state_t;

endpackage

// ===== rtl/lfs_exit_det.sv =====
// Exit condition detector: compares the sensor words against the mode thresholds.
// Depends on lfs_pkg.
module lfs_exit_det
    import lfs_pkg::*;
(
    input  logic [2:0] mode,
    input  sample_t    smp,
    output logic       hit
);

    always_comb
    begin
        case (mode)
            MODE_BULLSEYE:
                hit = (smp.blue_left > 16'd200) && (smp.blue_right > 16'd200)
                    && (smp.blue_third > 16'd600);
            MODE_SAFEZONE:
                hit = (smp.red_third < 16'd300) && (smp.green_third < 16'd300)
                    && (smp.blue_third < 16'd300);
            MODE_START:
                hit = (smp.green_left < 16'd150) && (smp.green_right < 16'd150);
            MODE_LEFT_RED:
                hit = smp.green_left < 16'd115;
            MODE_RIGHT_RED:
                hit = smp.green_right < 16'd135;
            MODE_THIRD_RED:
                hit = smp.green_third < 16'd300;
            default:
                hit = 1'b0;
        endcase
    end

endmodule

// ===== rtl/lfs_mul.sv =====
// Shared unsigned multiplier with registered product.
// Depends on lfs_pkg.
module lfs_mul
    import lfs_pkg::*;
(
    input  logic              clk,
    input  mul_req_t          req,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(req.opa) * PROD_W'(req.opb);
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/line_follow_steering_with_exit.sv =====
// Line-follow steering with exit detection: sequencer, run counter, config regs.
// Depends on lfs_pkg, lfs_exit_det, lfs_mul and assert_macros.svh.
// Steps: ST_IDLE takes a word; ST_NL, ST_NR, ST_SQ1, ST_SQ2, ST_GAIN; ST_FIN loads the output.
// A new word is taken only back in ST_IDLE; five passes through the shared multiplier.
// Output waits in its register; the sequencer holds in its last step until it is free.
// Reset: exit_mode 6, steer_gain 8192, exit_count 1, run counter 0; no clearing pass.
`include "assert_macros.svh"
module line_follow_steering_with_exit
    import lfs_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // red_third, green_third, blue_third, green_left, green_right, blue_left, blue_right
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // steering
    output logic [15:0]  m_axis_tdata,
    // exit_seen, steer_valid
    output logic [1:0]   m_axis_tuser,
    // run_done
    output logic         m_axis_tlast
);

    localparam logic [15:0] SampleMask = 16'((17'd1 << SAMPLE_BITS) - 17'd1);

    logic [2:0]  mode_reg;
    logic [15:0] gain_reg;
    logic [7:0]  count_reg;

    state_t      state_reg, state_next;
    logic [7:0]  dl_reg, dl_next;
    logic [8:0]  dr_reg, dr_next;
    logic        hit_reg, hit_next;
    logic [14:0] nl_reg, nl_next;
    logic        neg_reg, neg_next;
    logic [14:0] a4_reg, a4_next;
    logic [7:0]  run_reg, run_next;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] steer_reg, steer_next;
    logic        exit_seen_reg, exit_seen_next;
    logic        done_reg, done_next;

    sample_t           smp;
    logic              hit;
    mul_req_t          mul_req;
    logic [PROD_W-1:0] prod;

    logic [15:0] dl_full, dr_full;
    logic [14:0] nr, a_val, a2, a4;
    logic [28:0] sq_sum;
    logic [30:0] g_sum;
    logic [18:0] m_full;
    logic [15:0] m_sat;
    logic [8:0]  run_inc;
    logic [7:0]  need;

    assign smp.red_third   = s_axis_tdata[15:0]   & SampleMask;
    assign smp.green_third = s_axis_tdata[31:16]  & SampleMask;
    assign smp.blue_third  = s_axis_tdata[47:32]  & SampleMask;
    assign smp.green_left  = s_axis_tdata[63:48]  & SampleMask;
    assign smp.green_right = s_axis_tdata[79:64]  & SampleMask;
    assign smp.blue_left   = s_axis_tdata[95:80]  & SampleMask;
    assign smp.blue_right  = s_axis_tdata[111:96] & SampleMask;

    lfs_exit_det u_exit (
        .mode (mode_reg),
        .smp  (smp),
        .hit  (hit)
    );

    lfs_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);

    // tape offsets, floored at zero (clamped to span when the word is taken)
    assign dl_full = (smp.green_left > TAPE_L) ? smp.green_left - TAPE_L : 16'd0;
    assign dr_full = (smp.green_right > TAPE_R) ? smp.green_right - TAPE_R : 16'd0;

    assign nr     = prod[40:26];
    assign a_val  = (nr > nl_reg) ? nr - nl_reg : nl_reg - nr;
    assign sq_sum = prod[28:0] + 29'd8192;
    assign a2     = sq_sum[28:14];
    assign a4     = sq_sum[28:14];
    assign g_sum  = prod[30:0] + 31'd2048;
    assign m_full = g_sum[30:12];
    assign m_sat  = (m_full > 19'(ONE_Q14)) ? ONE_Q14 : m_full[15:0];
    assign run_inc = {1'b0, run_reg} + 9'd1;
    assign need    = (count_reg == 8'd0) ? 8'd1 : count_reg;

    always_comb
    begin
        state_next     = state_reg;
        dl_next        = dl_reg;
        dr_next        = dr_reg;
        hit_next       = hit_reg;
        nl_next        = nl_reg;
        neg_next       = neg_reg;
        a4_next        = a4_reg;
        run_next       = run_reg;
        out_valid_next = out_valid_reg;
        steer_next     = steer_reg;
        exit_seen_next = exit_seen_reg;
        done_next      = done_reg;
        mul_req        = '0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    dl_next    = (dl_full > SPAN_L) ? SPAN_L[7:0] : dl_full[7:0];
                    dr_next    = (dr_full > SPAN_R) ? SPAN_R[8:0] : dr_full[8:0];
                    hit_next   = hit;
                    state_next = ST_NL;
                end
            end
            ST_NL:
            begin
                mul_req.opa = MUL_W'({dl_reg, 11'd0} | HALF_L3);
                mul_req.opb = MUL_W'(RECIP_L);
                state_next  = ST_NR;
            end
            ST_NR:
            begin
                nl_next     = prod[38:24];
                mul_req.opa = MUL_W'({dr_reg, 11'd0} | HALF_R3);
                mul_req.opb = RECIP_R;
                state_next  = ST_SQ1;
            end
            ST_SQ1:
            begin
                neg_next    = nr > nl_reg;
                mul_req.opa = MUL_W'(a_val);
                mul_req.opb = MUL_W'(a_val);
                state_next  = ST_SQ2;
            end
            ST_SQ2:
            begin
                mul_req.opa = MUL_W'(a2);
                mul_req.opb = MUL_W'(a2);
                state_next  = ST_GAIN;
            end
            ST_GAIN:
            begin
                a4_next     = a4;
                mul_req.opa = MUL_W'(gain_reg);
                mul_req.opb = MUL_W'(a4);
                state_next  = ST_FIN;
            end
            ST_FIN:
            begin
                // keep the gain product steady while the output is busy
                mul_req.opa = MUL_W'(gain_reg);
                mul_req.opb = MUL_W'(a4_reg);
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    exit_seen_next = hit_reg;
                    if (hit_reg)
                        steer_next = 16'd0;
                    else if (neg_reg)
                        steer_next = 16'd0 - m_sat;
                    else
                        steer_next = m_sat;
                    done_next = 1'b0;
                    if ((mode_reg == MODE_TIMED) || hit_reg)
                    begin
                        if (run_inc >= {1'b0, need})
                        begin
                            done_next = 1'b1;
                            run_next  = 8'd0;
                        end
                        else
                        begin
                            run_next = run_inc[7:0];
                        end
                    end
                    else
                    begin
                        run_next = 8'd0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dl_reg        <= dl_next;
        dr_reg        <= dr_next;
        hit_reg       <= hit_next;
        nl_reg        <= nl_next;
        neg_reg       <= neg_next;
        a4_reg        <= a4_next;
        steer_reg     <= steer_next;
        exit_seen_reg <= exit_seen_next;
        done_reg      <= done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_TIMED;
            gain_reg  <= 16'd8192;
            count_reg <= 8'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_EXIT_MODE:  mode_reg  <= cfg_data[2:0];
                CFG_STEER_GAIN: gain_reg  <= cfg_data;
                CFG_EXIT_COUNT: count_reg <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = steer_reg;
    assign m_axis_tuser  = {exit_seen_reg, !exit_seen_reg};
    assign m_axis_tlast  = done_reg;

    `LFS_ASSERT(a_exit_no_steer, m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 16'd0, "steering on exit word")
    `LFS_ASSERT(a_steer_range, m_axis_tvalid |-> ($signed(m_axis_tdata) <= 16'sd16384) && ($signed(m_axis_tdata) >= -16'sd16384), "steering out of range")
    `LFS_ASSERT(a_done_clears, m_axis_tvalid && m_axis_tlast |-> run_reg == 8'd0, "run counter not cleared at run end")
    `LFS_NEVER(a_no_overwrite, (state_reg == ST_FIN) && (state_next == ST_IDLE) && out_valid_reg && !m_axis_tready, "output word overwritten")

endmodule
